>>> rtl/core/mmcrc_pkg.sv
// ----------------------------------------------------------------------------
// mmcrc_pkg
// Shared types and constants of the multi-mode CRC engine.
// ----------------------------------------------------------------------------
package mmcrc_pkg;

	typedef enum logic [1:0] {
		MODE_CRC16  = 2'd0,
		MODE_CCITT  = 2'd1,
		MODE_KERMIT = 2'd2,
		MODE_CRC32  = 2'd3
	} crc_mode_t;

	localparam int unsigned CRC_W = 32;

	localparam logic [15:0] POLY_CRC16  = 16'hA001;
	localparam logic [15:0] POLY_CCITT  = 16'h1021;
	localparam logic [15:0] POLY_KERMIT = 16'h8408;
	localparam logic [31:0] POLY_CRC32  = 32'hEDB88320;
	localparam logic [31:0] INIT_CRC32  = 32'hFFFFFFFF;

	function automatic logic [CRC_W-1:0] mode_init(input crc_mode_t mode);
		return (mode == MODE_CRC32) ? INIT_CRC32 : '0;
	endfunction

endpackage

>>> rtl/core/mmcrc_fold.sv
// ----------------------------------------------------------------------------
// mmcrc_fold
// Folds one byte into the CRC register, all eight bit steps unrolled.
// ----------------------------------------------------------------------------
module mmcrc_fold (
	input  mmcrc_pkg::crc_mode_t        mode,
	input  logic                        start_message,
	input  logic [7:0]                  data_byte,
	input  logic [mmcrc_pkg::CRC_W-1:0] crc,
	output logic [mmcrc_pkg::CRC_W-1:0] crc_next,
	output logic [mmcrc_pkg::CRC_W-1:0] checksum
);
	import mmcrc_pkg::*;

	function automatic logic [31:0] fold_refl(input logic [31:0] r, input logic [7:0] b,
	                                          input logic [31:0] poly);
		logic [31:0] v;
		v = r ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			v = v[0] ? ((v >> 1) ^ poly) : (v >> 1);
		end
		return v;
	endfunction

	function automatic logic [15:0] fold_msb(input logic [15:0] r, input logic [7:0] b,
	                                         input logic [15:0] poly);
		logic [15:0] v;
		v = r ^ {b, 8'd0};
		for (int k = 0; k < 8; k++) begin
			v = v[15] ? ((v << 1) ^ poly) : (v << 1);
		end
		return v;
	endfunction

	logic [CRC_W-1:0] crc_cur;
	logic [15:0]      low_cur;

	assign crc_cur = start_message ? mode_init(mode) : crc;
	assign low_cur = crc_cur[15:0];

	// A reflected fold only shifts right, so a 16-bit value keeps clear upper bits.
	always_comb begin
		unique case (mode)
			MODE_CRC16: begin
				crc_next = fold_refl({16'd0, low_cur}, data_byte, {16'd0, POLY_CRC16});
			end
			MODE_CCITT: begin
				crc_next = {16'd0, fold_msb(low_cur, data_byte, POLY_CCITT)};
			end
			MODE_KERMIT: begin
				crc_next = fold_refl({16'd0, low_cur}, data_byte, {16'd0, POLY_KERMIT});
			end
			MODE_CRC32: begin
				crc_next = fold_refl(crc_cur, data_byte, POLY_CRC32);
			end
			default: begin
				crc_next = '0;
			end
		endcase
	end

	// CRC-32 is reported inverted; the 16-bit modes already have clear upper bits.
	assign checksum = (mode == MODE_CRC32) ? ~crc_next : crc_next;

endmodule

>>> rtl/core/mmcrc_out_reg.sv
// ----------------------------------------------------------------------------
// mmcrc_out_reg
// Result register that holds one checksum word until the sink takes it.
// ----------------------------------------------------------------------------
module mmcrc_out_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [mmcrc_pkg::CRC_W-1:0] push_data,
	output logic                        can_push,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mmcrc_pkg::CRC_W-1:0] checksum
);
	import mmcrc_pkg::*;

	logic             valid_q;
	logic [CRC_W-1:0] data_q;

	// The register frees up in the same cycle its word is taken.
	assign can_push  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign checksum  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_push) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && can_push) begin
			data_q <= push_data;
		end
	end

endmodule

>>> rtl/core/multi_mode_crc_engine_unit.sv
// ----------------------------------------------------------------------------
// multi_mode_crc_engine_unit
// Byte-wide CRC engine for CRC-16, CCITT, Kermit and CRC-32.
// ----------------------------------------------------------------------------
// One message byte is accepted per cycle, unless a chunk-end byte is waiting
// on a full result register whose word the sink is stalling. A byte is
// registered on input, then folded into the running CRC by the unrolled
// eight-step update as it leaves that register, which also loads the result
// register, so a checksum passes the input and result registers before it
// reaches the output. The loop through the CRC register sets the rate. A
// word with start_message set reloads the mode's initial value first.
// Writing crc_mode reloads the CRC register too; write it only while idle.
module multi_mode_crc_engine_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        crc_mode_valid,
	output logic                        crc_mode_ready,
	input  logic [1:0]                  crc_mode,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  data_byte,
	input  logic                        start_message,
	input  logic                        end_of_chunk,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mmcrc_pkg::CRC_W-1:0] checksum
);
	import mmcrc_pkg::*;

	crc_mode_t        mode_q;
	logic [CRC_W-1:0] crc_q;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             start_s1;
	logic             end_s1;

	logic [CRC_W-1:0] crc_next;
	logic [CRC_W-1:0] sum_next;
	logic             can_push;
	logic             adv_s1;
	logic             load_s1;

	assign crc_mode_ready = 1'b1;

	// A word without end_of_chunk never waits on the output side.
	assign adv_s1   = valid_s1 && (!end_s1 || can_push);
	assign in_stall = valid_s1 && !adv_s1;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1  <= data_byte;
			start_s1 <= start_message;
			end_s1   <= end_of_chunk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CRC16;
			crc_q  <= mode_init(MODE_CRC16);
		end else if (crc_mode_valid) begin
			mode_q <= crc_mode_t'(crc_mode);
			crc_q  <= mode_init(crc_mode_t'(crc_mode));
		end else if (adv_s1) begin
			crc_q <= crc_next;
		end
	end

	mmcrc_fold u_fold (
		.mode          (mode_q),
		.start_message (start_s1),
		.data_byte     (byte_s1),
		.crc           (crc_q),
		.crc_next      (crc_next),
		.checksum      (sum_next)
	);

	mmcrc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv_s1 && end_s1),
		.push_data (sum_next),
		.can_push  (can_push),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.checksum  (checksum)
	);

endmodule
